FILE: sv/tftpc_pkg.sv
`timescale 1ns / 1ps

package tftpc_pkg;

	localparam int BLOCK_SIZE = 512;
	localparam logic [9:0]  BLOCK_SIZE_CL = 10'(BLOCK_SIZE);
	localparam logic [15:0] BLOCK_SIZE_PL = 16'(BLOCK_SIZE);

	localparam logic [15:0] INIT_SERVER_PORT = 16'd69;
	localparam logic [31:0] INIT_TIMEOUT     = 32'd1000;

	localparam logic [15:0] M10_RECIP = 16'd52429;

	localparam logic [1:0] CFG_PUSH_MODE = 2'd0;
	localparam logic [1:0] CFG_TIMEOUT   = 2'd1;
	localparam logic [1:0] CFG_PORT      = 2'd2;

	localparam logic [1:0] EV_START  = 2'd0;
	localparam logic [1:0] EV_PACKET = 2'd1;
	localparam logic [1:0] EV_TICK   = 2'd2;
	localparam logic [1:0] EV_ABORT  = 2'd3;

	localparam logic [15:0] PKT_DATA  = 16'd3;
	localparam logic [15:0] PKT_ACK   = 16'd4;
	localparam logic [15:0] PKT_ERROR = 16'd5;
	localparam logic [15:0] PKT_OACK  = 16'd6;

	localparam logic [15:0] TFTP_ERR_NOT_FOUND = 16'd1;
	localparam logic [15:0] TFTP_ERR_ACCESS    = 16'd2;

	localparam logic [2:0] SEND_NONE = 3'd0;
	localparam logic [2:0] SEND_RRQ  = 3'd1;
	localparam logic [2:0] SEND_WRQ  = 3'd2;
	localparam logic [2:0] SEND_DATA = 3'd3;
	localparam logic [2:0] SEND_ACK  = 3'd4;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NOT_FOUND = 3'd1;
	localparam logic [2:0] ERR_ACCESS    = 3'd2;
	localparam logic [2:0] ERR_PROTOCOL  = 3'd3;
	localparam logic [2:0] ERR_LOCAL_IO  = 3'd4;
	localparam logic [2:0] ERR_ABORTED   = 3'd5;

	localparam logic [2:0] PHC_IDLE  = 3'd0;
	localparam logic [2:0] PHC_RRQ   = 3'd1;
	localparam logic [2:0] PHC_WRQ   = 3'd2;
	localparam logic [2:0] PHC_RDATA = 3'd3;
	localparam logic [2:0] PHC_WDATA = 3'd4;
	localparam logic [2:0] PHC_OACK  = 3'd5;
	localparam logic [2:0] PHC_LAST  = 3'd6;
	localparam logic [2:0] PHC_DONE  = 3'd7;

	typedef enum logic [7:0] {
		PH_IDLE  = 8'b0000_0001,
		PH_RRQ   = 8'b0000_0010,
		PH_WRQ   = 8'b0000_0100,
		PH_RDATA = 8'b0000_1000,
		PH_WDATA = 8'b0001_0000,
		PH_OACK  = 8'b0010_0000,
		PH_LAST  = 8'b0100_0000,
		PH_DONE  = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic        push_mode;
		logic [31:0] timeout_ticks;
		logic [15:0] initial_server_port;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] pkt_opcode;
		logic [15:0] pkt_word;
		logic [15:0] udp_len;
		logic [15:0] src_port;
		logic [9:0]  chunk_len;
		logic        io_error;
	} evt_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] block_num;
		logic [15:0] last_block_num;
		logic [15:0] server_port;
		logic [9:0]  last_send_len;
		logic [31:0] idle_ticks;
		logic [31:0] progress_count;
		logic [2:0]  error_code;
	} st_t;

	typedef struct packed {
		logic [2:0]  send_kind;
		logic [15:0] send_block;
		logic [9:0]  send_data_len;
		logic [15:0] dest_port;
		logic        fetch_chunk;
		logic        store_payload;
		logic [15:0] payload_len;
		logic [2:0]  phase;
		logic        done_res;
		logic [2:0]  error_code;
		logic [31:0] progress;
	} res_t;

	function automatic logic [2:0] phase_code(input phase_t ph);
		logic [2:0] c;
		case (ph)
			PH_IDLE:  c = PHC_IDLE;
			PH_RRQ:   c = PHC_RRQ;
			PH_WRQ:   c = PHC_WRQ;
			PH_RDATA: c = PHC_RDATA;
			PH_WDATA: c = PHC_WDATA;
			PH_OACK:  c = PHC_OACK;
			PH_LAST:  c = PHC_LAST;
			PH_DONE:  c = PHC_DONE;
			default:  c = PHC_IDLE;
		endcase
		return c;
	endfunction

	// block number is a multiple of ten: reciprocal multiply, then check back
	function automatic logic mod10_zero(input logic [15:0] w);
		logic [31:0] prod;
		logic [12:0] q;
		logic [15:0] back;
		prod = {16'd0, w} * {16'd0, M10_RECIP};
		q    = prod[31:19];
		back = 16'({q, 3'b000}) + 16'({q, 1'b0});
		return back == w;
	endfunction

endpackage

FILE: sv/tftpc_cfg.sv
`timescale 1ns / 1ps

module tftpc_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_wdata,
	output tftpc_pkg::cfg_t     cfg
);

	tftpc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.push_mode           <= 1'b0;
			cfg_q.timeout_ticks       <= tftpc_pkg::INIT_TIMEOUT;
			cfg_q.initial_server_port <= tftpc_pkg::INIT_SERVER_PORT;
		end else if (cfg_we) begin
			case (cfg_index)
				tftpc_pkg::CFG_PUSH_MODE: cfg_q.push_mode           <= cfg_wdata[0];
				tftpc_pkg::CFG_TIMEOUT:   cfg_q.timeout_ticks       <= cfg_wdata;
				tftpc_pkg::CFG_PORT:      cfg_q.initial_server_port <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/tftpc_step.sv
`timescale 1ns / 1ps

module tftpc_step (
	input  tftpc_pkg::st_t  st,
	input  tftpc_pkg::evt_t evt,
	input  tftpc_pkg::cfg_t cfg,
	input  logic            blk_m10,
	output tftpc_pkg::st_t  nxt,
	output tftpc_pkg::res_t res
);

	tftpc_pkg::st_t  p;
	tftpc_pkg::st_t  n;
	tftpc_pkg::res_t r;
	logic            active;
	logic            want;
	logic            sent;
	logic            data_end;
	logic            stopped;
	logic [9:0]      e_chunk;
	logic            e_ioe;
	logic [9:0]      nn;
	logic [15:0]     plen;

	always_comb begin
		p        = st;
		r        = '0;
		want     = 1'b0;
		sent     = 1'b0;
		data_end = 1'b0;
		stopped  = 1'b0;
		e_chunk  = evt.chunk_len;
		e_ioe    = evt.io_error;
		nn       = (evt.chunk_len > tftpc_pkg::BLOCK_SIZE_CL) ?
			tftpc_pkg::BLOCK_SIZE_CL : evt.chunk_len;
		plen     = evt.udp_len - 16'd4;
		active   = (st.phase != tftpc_pkg::PH_IDLE) && (st.phase != tftpc_pkg::PH_DONE);

		case (evt.opcode)
			tftpc_pkg::EV_START: begin
				p.last_block_num = '0;
				p.progress_count = '0;
				p.error_code     = tftpc_pkg::ERR_NONE;
				p.server_port    = cfg.initial_server_port;
				p.phase          = cfg.push_mode ? tftpc_pkg::PH_WRQ : tftpc_pkg::PH_RRQ;
				p.block_num      = 16'd1;
				want             = 1'b1;
				e_chunk          = '0;
				e_ioe            = 1'b0;
			end
			tftpc_pkg::EV_PACKET: begin
				if (active && evt.udp_len >= 16'd2) begin
					case (evt.pkt_opcode)
						tftpc_pkg::PKT_ACK: begin
							if (cfg.push_mode && evt.pkt_word == st.last_block_num) begin
								p.block_num = evt.pkt_word + 16'd1;
								if (st.phase == tftpc_pkg::PH_LAST) begin
									p.phase = tftpc_pkg::PH_DONE;
								end else begin
									p.server_port = evt.src_port;
									p.phase       = tftpc_pkg::PH_WDATA;
									want          = 1'b1;
								end
							end
						end
						tftpc_pkg::PKT_OACK: begin
							p.server_port = evt.src_port;
							if (cfg.push_mode) begin
								p.phase     = tftpc_pkg::PH_WDATA;
								p.block_num = 16'd1;
							end else begin
								p.phase     = tftpc_pkg::PH_OACK;
								p.block_num = 16'd0;
							end
							want = 1'b1;
						end
						tftpc_pkg::PKT_DATA: begin
							if (evt.udp_len >= 16'd4) begin
								p.block_num = evt.pkt_word;
								if (st.phase == tftpc_pkg::PH_RRQ ||
								    st.phase == tftpc_pkg::PH_OACK) begin
									p.phase          = tftpc_pkg::PH_RDATA;
									p.server_port    = evt.src_port;
									p.last_block_num = '0;
									if (evt.pkt_word != 16'd1) begin
										p.error_code = tftpc_pkg::ERR_PROTOCOL;
										p.phase      = tftpc_pkg::PH_DONE;
										stopped      = 1'b1;
									end
								end
								if (!stopped && evt.pkt_word != p.last_block_num) begin
									p.last_block_num = evt.pkt_word;
									if (blk_m10)
										p.progress_count = p.progress_count + 32'd1;
									r.store_payload = 1'b1;
									r.payload_len   = plen;
									if (evt.io_error) begin
										p.error_code = tftpc_pkg::ERR_LOCAL_IO;
										p.phase      = tftpc_pkg::PH_DONE;
									end else begin
										want     = 1'b1;
										data_end = plen < tftpc_pkg::BLOCK_SIZE_PL;
									end
								end
							end
						end
						tftpc_pkg::PKT_ERROR: begin
							p.phase = tftpc_pkg::PH_DONE;
							if (evt.pkt_word == tftpc_pkg::TFTP_ERR_NOT_FOUND)
								p.error_code = tftpc_pkg::ERR_NOT_FOUND;
							else if (evt.pkt_word == tftpc_pkg::TFTP_ERR_ACCESS)
								p.error_code = tftpc_pkg::ERR_ACCESS;
							else
								p.error_code = tftpc_pkg::ERR_PROTOCOL;
						end
						default: ;
					endcase
				end
			end
			tftpc_pkg::EV_TICK: begin
				if (active) begin
					p.idle_ticks = st.idle_ticks + 32'd1;
					want         = p.idle_ticks >= cfg.timeout_ticks;
				end
			end
			tftpc_pkg::EV_ABORT: begin
				if (active) begin
					p.error_code = tftpc_pkg::ERR_ABORTED;
					p.phase      = tftpc_pkg::PH_DONE;
				end
			end
			default: ;
		endcase

		n = p;
		if (e_chunk != evt.chunk_len)
			nn = '0;
		if (want) begin
			case (p.phase)
				tftpc_pkg::PH_RRQ: begin
					sent        = 1'b1;
					r.send_kind = tftpc_pkg::SEND_RRQ;
				end
				tftpc_pkg::PH_WRQ: begin
					sent        = 1'b1;
					r.send_kind = tftpc_pkg::SEND_WRQ;
				end
				tftpc_pkg::PH_RDATA, tftpc_pkg::PH_OACK: begin
					sent         = 1'b1;
					r.send_kind  = tftpc_pkg::SEND_ACK;
					r.send_block = p.block_num;
				end
				tftpc_pkg::PH_LAST: begin
					sent            = 1'b1;
					r.send_kind     = tftpc_pkg::SEND_DATA;
					r.send_block    = p.last_block_num;
					r.send_data_len = p.last_send_len;
				end
				tftpc_pkg::PH_WDATA: begin
					if (p.last_block_num != p.block_num) begin
						n.last_block_num = p.block_num;
						if (e_ioe) begin
							n.error_code = tftpc_pkg::ERR_LOCAL_IO;
							n.phase      = tftpc_pkg::PH_DONE;
						end else begin
							sent             = 1'b1;
							r.fetch_chunk    = 1'b1;
							n.progress_count = p.progress_count + {22'd0, nn};
							if (nn < tftpc_pkg::BLOCK_SIZE_CL)
								n.phase = tftpc_pkg::PH_LAST;
							n.last_send_len  = nn;
							r.send_kind      = tftpc_pkg::SEND_DATA;
							r.send_block     = p.block_num;
							r.send_data_len  = nn;
						end
					end else begin
						sent            = 1'b1;
						r.send_kind     = tftpc_pkg::SEND_DATA;
						r.send_block    = p.block_num;
						r.send_data_len = p.last_send_len;
					end
				end
				default: ;
			endcase
		end
		if (sent) begin
			r.dest_port  = p.server_port;
			n.idle_ticks = '0;
		end
		if (data_end)
			n.phase = tftpc_pkg::PH_DONE;

		r.phase      = tftpc_pkg::phase_code(n.phase);
		r.done_res   = n.phase == tftpc_pkg::PH_DONE;
		r.error_code = n.error_code;
		r.progress   = n.progress_count;
	end

	assign nxt = n;
	assign res = r;

endmodule

FILE: sv/tftp_client_transfer_control.sv
`timescale 1ns / 1ps

// channel   | handshake           | words
// ----------+---------------------+---------------------------------------------
// event in  | in_valid / in_ready | opcode pkt_opcode pkt_word udp_len src_port
//           |                     | chunk_len io_error
// result    | out_valid/out_ready | send_kind send_block send_data_len dest_port
//           |                     | fetch_chunk store_payload payload_len phase
//           |                     | done_res error_code progress
// config    | cfg_we              | cfg_index cfg_wdata
//
// One event word per cycle unless out_ready low holds a result. Input register, then
// the transfer update and result register in one pass.
// arst_n clears phase to idle, counters and block numbers to zero, the server
// port to 69 and the configuration to its defaults.
// out_ready low holds the result; the input register still takes one word.

module tftp_client_transfer_control (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [15:0] pkt_opcode,
	input  logic [15:0] pkt_word,
	input  logic [15:0] udp_len,
	input  logic [15:0] src_port,
	input  logic [9:0]  chunk_len,
	input  logic        io_error,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  send_kind,
	output logic [15:0] send_block,
	output logic [9:0]  send_data_len,
	output logic [15:0] dest_port,
	output logic        fetch_chunk,
	output logic        store_payload,
	output logic [15:0] payload_len,
	output logic [2:0]  phase,
	output logic        done_res,
	output logic [2:0]  error_code,
	output logic [31:0] progress
);

	tftpc_pkg::cfg_t cfg;
	tftpc_pkg::evt_t evt_in;
	tftpc_pkg::evt_t evt_s1;
	logic            m10_s1;
	logic            valid_s1;
	tftpc_pkg::st_t  st_q;
	tftpc_pkg::st_t  st_nxt;
	tftpc_pkg::res_t res_nxt;
	tftpc_pkg::res_t res_s2;
	logic            valid_s2;
	logic            advance;

	tftpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign evt_in.opcode     = opcode;
	assign evt_in.pkt_opcode = pkt_opcode;
	assign evt_in.pkt_word   = pkt_word;
	assign evt_in.udp_len    = udp_len;
	assign evt_in.src_port   = src_port;
	assign evt_in.chunk_len  = chunk_len;
	assign evt_in.io_error   = io_error;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			evt_s1 <= evt_in;
			m10_s1 <= tftpc_pkg::mod10_zero(pkt_word);
		end
	end

	tftpc_step u_step (
		.st      (st_q),
		.evt     (evt_s1),
		.cfg     (cfg),
		.blk_m10 (m10_s1),
		.nxt     (st_nxt),
		.res     (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase          <= tftpc_pkg::PH_IDLE;
			st_q.block_num      <= '0;
			st_q.last_block_num <= '0;
			st_q.server_port    <= tftpc_pkg::INIT_SERVER_PORT;
			st_q.last_send_len  <= '0;
			st_q.idle_ticks     <= '0;
			st_q.progress_count <= '0;
			st_q.error_code     <= tftpc_pkg::ERR_NONE;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (out_ready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_nxt;
	end

	assign out_valid     = valid_s2;
	assign send_kind     = res_s2.send_kind;
	assign send_block    = res_s2.send_block;
	assign send_data_len = res_s2.send_data_len;
	assign dest_port     = res_s2.dest_port;
	assign fetch_chunk   = res_s2.fetch_chunk;
	assign store_payload = res_s2.store_payload;
	assign payload_len   = res_s2.payload_len;
	assign phase         = res_s2.phase;
	assign done_res      = res_s2.done_res;
	assign error_code    = res_s2.error_code;
	assign progress      = res_s2.progress;

`ifndef NO_ASSERTIONS
	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("result register not loaded after update");

	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (done_res == (phase == tftpc_pkg::PHC_DONE)))
		else $error("done status disagrees with phase");

	a_no_send_port: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && send_kind == tftpc_pkg::SEND_NONE) |-> (dest_port == 16'd0))
		else $error("port given with no send");

	a_store_len: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !store_payload) |-> (payload_len == 16'd0))
		else $error("payload length without store");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (st_q.phase == tftpc_pkg::PH_IDLE || st_q.phase == tftpc_pkg::PH_DONE)
		 && evt_s1.opcode != tftpc_pkg::EV_START) |=> (send_kind == tftpc_pkg::SEND_NONE))
		else $error("send while no transfer active");
`endif

endmodule
